FILE: hdl/macd_pkg.sv
// Shared types and constants of the MACD indicator filter.
package macd_pkg;

  localparam int unsigned PRICE_W = 31;
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned MACD_W  = 34;
  localparam int unsigned SUM_W   = 36;

  localparam logic [1:0] CFG_SHORT_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_LONG_ALPHA   = 2'd1;
  localparam logic [1:0] CFG_SIGNAL_ALPHA = 2'd2;

  localparam logic [ALPHA_W-1:0] SHORT_ALPHA_RST  = 17'd10082;
  localparam logic [ALPHA_W-1:0] LONG_ALPHA_RST   = 17'd4855;
  localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 17'd13107;

  localparam logic signed [SUM_W-1:0] PRICE_HI = 36'sd2147483647;
  localparam logic signed [SUM_W-1:0] S32_HI   = 36'sd2147483647;
  localparam logic signed [SUM_W-1:0] S32_LO   = -36'sd2147483648;

  typedef struct packed {
    logic signed [VAL_W-1:0] avg;
    logic signed [VAL_W-1:0] target;
    logic [ALPHA_W-1:0]      alpha;
    logic                    sig_clamp;
  } ema_op_t;

endpackage

FILE: hdl/macd_ema_unit.sv
// Shared EMA step unit: registered (x - e) * alpha, then floor shift, add and clamp.
module macd_ema_unit (
  input  logic                                clk,
  input  macd_pkg::ema_op_t                   op,
  output logic signed [macd_pkg::VAL_W-1:0]   result
);

  logic signed [macd_pkg::VAL_W:0]              diff;
  logic signed [macd_pkg::ALPHA_W:0]            alpha_s;
  logic signed [macd_pkg::VAL_W+macd_pkg::ALPHA_W+1:0] prod_r;
  logic signed [macd_pkg::VAL_W-1:0]            avg_r;
  logic                                         clamp_r;
  logic signed [macd_pkg::VAL_W+macd_pkg::ALPHA_W-15:0] step;
  logic signed [macd_pkg::SUM_W-1:0]            sum;

  assign diff    = {op.target[macd_pkg::VAL_W-1], op.target} -
                   {op.avg[macd_pkg::VAL_W-1], op.avg};
  assign alpha_s = {1'b0, op.alpha};

  always_ff @(posedge clk) begin
    prod_r  <= diff * alpha_s;
    avg_r   <= op.avg;
    clamp_r <= op.sig_clamp;
  end

  // floor divide by 2^16
  assign step = prod_r[macd_pkg::VAL_W+macd_pkg::ALPHA_W+1:16];
  assign sum  = {{4{avg_r[macd_pkg::VAL_W-1]}}, avg_r} +
                {step[macd_pkg::VAL_W+macd_pkg::ALPHA_W-15], step};

  always_comb begin
    if (clamp_r) begin
      if (sum < macd_pkg::S32_LO) begin
        result = macd_pkg::S32_LO[macd_pkg::VAL_W-1:0];
      end else if (sum > macd_pkg::S32_HI) begin
        result = macd_pkg::S32_HI[macd_pkg::VAL_W-1:0];
      end else begin
        result = sum[macd_pkg::VAL_W-1:0];
      end
    end else begin
      if (sum < 0) begin
        result = '0;
      end else if (sum > macd_pkg::PRICE_HI) begin
        result = macd_pkg::PRICE_HI[macd_pkg::VAL_W-1:0];
      end else begin
        result = sum[macd_pkg::VAL_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/macd_indicator_filter.sv
// MACD indicator filter top level: sequencer, EMA state, config and output register.
//
// Input channel: one price sample per item (in_tdata), in_tuser = restart.
// The first item after reset, or any item with restart set, loads both price
// EMAs with the price and clears DEA; its result is all zero.
// Otherwise the short, long and signal EMAs are updated in turn on one shared
// multiply-accumulate unit, each as a registered multiply, then add and clamp.
// Result channel: DIF, DEA and MACD = 2*(DIF - DEA) per item.
// A normal sample passes the states SHORT, LONG, LWAIT, SIG, SWAIT and DONE
// before out_tvalid rises; a series start goes from idle straight to DONE.
// The three EMA steps run in sequence through the single multiplier, so a
// new item is taken only once the sequencer is back in idle.
// in_tready is high only while the sequencer is idle. The output register
// holds a result until taken; the next item is accepted meanwhile and waits
// at its end for the register to free up when the receiver stalls.
// Reset (rst_n low, synchronous) clears the EMAs, the series flag and the
// output valid, and loads the default smoothing factors.
// Config writes (cfg_wr_en) take effect at once; write only while idle.
module macd_indicator_filter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [30:0] price, [31] zero
  input  logic         in_tuser,   // [0] restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // [31:0] dif_value, [63:32] dea_value,
                                   // [97:64] macd_value, [103:98] zero
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHORT, ST_LONG, ST_LWAIT, ST_SIG, ST_SWAIT, ST_DONE
  } state_t;

  state_t                                   state_r;
  logic [macd_pkg::ALPHA_W-1:0]             short_alpha_r;
  logic [macd_pkg::ALPHA_W-1:0]             long_alpha_r;
  logic [macd_pkg::ALPHA_W-1:0]             signal_alpha_r;
  logic [macd_pkg::PRICE_W-1:0]             price_r;
  logic [macd_pkg::PRICE_W-1:0]             short_r;
  logic [macd_pkg::PRICE_W-1:0]             long_r;
  logic signed [macd_pkg::VAL_W-1:0]        signal_r;
  logic                                     started_r;
  logic                                     out_valid_r;
  logic [103:0]                             out_data_r;
  macd_pkg::ema_op_t                        op;
  logic signed [macd_pkg::VAL_W-1:0]        ema_res;
  logic signed [macd_pkg::VAL_W-1:0]        dif;
  logic signed [macd_pkg::VAL_W:0]          gap;
  logic                                     in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign dif = $signed({1'b0, short_r}) - $signed({1'b0, long_r});
  assign gap = {dif[macd_pkg::VAL_W-1], dif} - {signal_r[macd_pkg::VAL_W-1], signal_r};

  always_comb begin
    unique case (state_r)
      ST_SHORT: begin
        op = '{avg: $signed({1'b0, short_r}), target: $signed({1'b0, price_r}),
               alpha: short_alpha_r, sig_clamp: 1'b0};
      end
      ST_LONG: begin
        op = '{avg: $signed({1'b0, long_r}), target: $signed({1'b0, price_r}),
               alpha: long_alpha_r, sig_clamp: 1'b0};
      end
      default: begin
        op = '{avg: signal_r, target: dif, alpha: signal_alpha_r, sig_clamp: 1'b1};
      end
    endcase
  end

  macd_ema_unit u_ema (
    .clk    (clk),
    .op     (op),
    .result (ema_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_alpha_r  <= macd_pkg::SHORT_ALPHA_RST;
      long_alpha_r   <= macd_pkg::LONG_ALPHA_RST;
      signal_alpha_r <= macd_pkg::SIGNAL_ALPHA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        macd_pkg::CFG_SHORT_ALPHA:  short_alpha_r  <= cfg_wdata;
        macd_pkg::CFG_LONG_ALPHA:   long_alpha_r   <= cfg_wdata;
        macd_pkg::CFG_SIGNAL_ALPHA: signal_alpha_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      price_r     <= '0;
      short_r     <= '0;
      long_r      <= '0;
      signal_r    <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            price_r <= in_tdata[macd_pkg::PRICE_W-1:0];
            if (in_tuser || !started_r) begin
              short_r   <= in_tdata[macd_pkg::PRICE_W-1:0];
              long_r    <= in_tdata[macd_pkg::PRICE_W-1:0];
              signal_r  <= '0;
              started_r <= 1'b1;
              state_r   <= ST_DONE;
            end else begin
              state_r <= ST_SHORT;
            end
          end
        end
        ST_SHORT: state_r <= ST_LONG;
        ST_LONG: begin
          short_r <= ema_res[macd_pkg::PRICE_W-1:0];
          state_r <= ST_LWAIT;
        end
        ST_LWAIT: begin
          long_r  <= ema_res[macd_pkg::PRICE_W-1:0];
          state_r <= ST_SIG;
        end
        ST_SIG: state_r <= ST_SWAIT;
        ST_SWAIT: begin
          signal_r <= ema_res;
          state_r  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'b0, gap, 1'b0, signal_r, dif};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/macd_checker.sv
// Port-level checks of the MACD indicator filter, bound to the top level.
module macd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  logic signed [32:0] gap;

  assign gap = {out_tdata[31], out_tdata[31:0]} - {out_tdata[63], out_tdata[63:32]};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while sequencer busy");

  a_macd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[97:64] == {gap, 1'b0})
    else $error("macd is not twice dif minus dea");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind macd_indicator_filter macd_checker u_macd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the MACD indicator filter: directed table, then random price series.
module tb_top;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PHASE_ITEMS    = 193;
  localparam int unsigned HOLD_PHASE     = 4;
  localparam int unsigned PAUSE_PHASE    = 6;
  localparam int unsigned NUM_DIRECTED   = 22;
  localparam logic [macd_pkg::ALPHA_W-1:0] ALPHA_TOP = 17'h1FFFF;
  localparam logic [macd_pkg::PRICE_W-1:0] PRICE_TOP = 31'h7FFFFFFF;

  typedef struct packed {
    logic signed [macd_pkg::VAL_W-1:0]  dif;
    logic signed [macd_pkg::VAL_W-1:0]  dea;
    logic signed [macd_pkg::MACD_W-1:0] macd;
  } macd_result_t;

  typedef struct packed {
    logic [macd_pkg::PRICE_W-1:0] price;
    logic                         restart;
    logic                         typed;
    macd_result_t                 want;
  } stim_row_t;

  localparam macd_result_t ALL_ZERO = '0;

  // typed rows are series starts: all-zero result
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{31'h0,        1'b0, 1'b1, ALL_ZERO},
    '{PRICE_TOP,    1'b0, 1'b0, ALL_ZERO},
    '{31'h0,        1'b0, 1'b0, ALL_ZERO},
    '{PRICE_TOP,    1'b0, 1'b0, ALL_ZERO},
    '{PRICE_TOP,    1'b0, 1'b0, ALL_ZERO},
    '{PRICE_TOP,    1'b1, 1'b1, ALL_ZERO},
    '{31'h0,        1'b0, 1'b0, ALL_ZERO},
    '{31'h0,        1'b0, 1'b0, ALL_ZERO},
    '{31'h1,        1'b0, 1'b0, ALL_ZERO},
    '{31'h0,        1'b1, 1'b1, ALL_ZERO},
    '{31'h40000000, 1'b0, 1'b0, ALL_ZERO},
    '{31'h3FFFFFFF, 1'b0, 1'b0, ALL_ZERO},
    '{31'h00010000, 1'b0, 1'b0, ALL_ZERO},
    '{31'h12345678, 1'b1, 1'b1, ALL_ZERO},
    '{31'h55555555, 1'b0, 1'b0, ALL_ZERO},
    '{31'h2AAAAAAA, 1'b0, 1'b0, ALL_ZERO},
    '{31'h12345677, 1'b0, 1'b0, ALL_ZERO},
    '{31'h12345676, 1'b0, 1'b0, ALL_ZERO},
    '{31'h00000001, 1'b1, 1'b1, ALL_ZERO},
    '{PRICE_TOP,    1'b0, 1'b0, ALL_ZERO},
    '{31'h00000002, 1'b0, 1'b0, ALL_ZERO},
    '{31'h7FFF0000, 1'b0, 1'b0, ALL_ZERO}
  };

  // short, long, signal
  localparam logic [macd_pkg::ALPHA_W-1:0] PHASE_ALPHA [NUM_PHASES][3] = '{
    '{17'd10082,  17'd4855,   17'd13107},
    '{17'd65536,  17'd65536,  17'd65536},
    '{17'd0,      17'd0,      17'd0},
    '{ALPHA_TOP,  ALPHA_TOP,  ALPHA_TOP},
    '{ALPHA_TOP,  17'd1,      17'd65536},
    '{17'd0,      17'd0,      17'd0},
    '{17'd32768,  17'd3,      17'd99999},
    '{17'd0,      17'd0,      17'd0},
    '{17'd21845,  17'd2427,   17'd6553},
    '{17'd10082,  17'd4855,   17'd13107}
  };
  localparam bit PHASE_RANDOM_ALPHA [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 0, 1, 0, 0};

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [16:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;   // [30:0] price, [31] zero
  logic         in_tuser;   // [0] restart
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;  // [31:0] dif_value, [63:32] dea_value, [97:64] macd_value

  macd_indicator_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state
  logic [macd_pkg::ALPHA_W-1:0] alpha_short  = macd_pkg::SHORT_ALPHA_RST;
  logic [macd_pkg::ALPHA_W-1:0] alpha_long   = macd_pkg::LONG_ALPHA_RST;
  logic [macd_pkg::ALPHA_W-1:0] alpha_signal = macd_pkg::SIGNAL_ALPHA_RST;
  longint                       fast_avg     = 0;
  longint                       slow_avg     = 0;
  longint                       signal_ema   = 0;
  bit                           series_live  = 1'b0;

  macd_result_t pending_results [$];
  macd_result_t want_res;
  macd_result_t got_res;
  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;
  bit           idling      = 1'b1;
  bit           hold_rx     = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // e + floor((x - e) * alpha / 2^16)
  function automatic longint ema_update(longint avg, longint target,
                                        logic [macd_pkg::ALPHA_W-1:0] alpha);
    longint prod;
    prod = (target - avg) * longint'(alpha);
    return avg + (prod >>> 16);
  endfunction

  function automatic macd_result_t predict_macd(logic [macd_pkg::PRICE_W-1:0] price,
                                                logic restart);
    macd_result_t res;
    longint       px;
    longint       dif;
    longint       osc;
    px = longint'(price);
    if (restart || !series_live) begin
      fast_avg    = px;
      slow_avg    = px;
      signal_ema  = 0;
      series_live = 1'b1;
      dif         = 0;
    end else begin
      fast_avg   = sat(ema_update(fast_avg, px, alpha_short), 0,
                       longint'(macd_pkg::PRICE_HI));
      slow_avg   = sat(ema_update(slow_avg, px, alpha_long), 0,
                       longint'(macd_pkg::PRICE_HI));
      dif        = fast_avg - slow_avg;
      signal_ema = sat(ema_update(signal_ema, dif, alpha_signal),
                       longint'(macd_pkg::S32_LO), longint'(macd_pkg::S32_HI));
    end
    osc      = 2 * (dif - signal_ema);
    res.dif  = dif[macd_pkg::VAL_W-1:0];
    res.dea  = signal_ema[macd_pkg::VAL_W-1:0];
    res.macd = osc[macd_pkg::MACD_W-1:0];
    return res;
  endfunction

  task automatic write_alpha(input logic [1:0] idx,
                             input logic [macd_pkg::ALPHA_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      macd_pkg::CFG_SHORT_ALPHA:  alpha_short  = value;
      macd_pkg::CFG_LONG_ALPHA:   alpha_long   = value;
      macd_pkg::CFG_SIGNAL_ALPHA: alpha_signal = value;
      default: ;
    endcase
  endtask

  task automatic sender_gap();
    if (idling && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_price(input logic [macd_pkg::PRICE_W-1:0] price, input logic restart,
                            input logic typed, input macd_result_t want);
    macd_result_t predicted;
    in_tdata  = {1'b0, price};
    in_tuser  = restart;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = predict_macd(price, restart);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_tready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_rx    = 1'b0;
        out_tready = 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.dif  = out_tdata[31:0];
      got_res.dea  = out_tdata[63:32];
      got_res.macd = out_tdata[97:64];
      if (pending_results.size() == 0) begin
        $error("result with no item pending: dif %0d dea %0d macd %0d",
               got_res.dif, got_res.dea, got_res.macd);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.dif !== want_res.dif) begin
          $error("dif_value: expected %0d, got %0d", want_res.dif, got_res.dif);
          fail_count++;
        end
        if (got_res.dea !== want_res.dea) begin
          $error("dea_value: expected %0d, got %0d", want_res.dea, got_res.dea);
          fail_count++;
        end
        if (got_res.macd !== want_res.macd) begin
          $error("macd_value: expected %0d, got %0d", want_res.macd, got_res.macd);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** macd_indicator_filter: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned                  phase;
    int unsigned                  n;
    int unsigned                  span;
    longint                       level;
    logic [macd_pkg::PRICE_W-1:0] price;
    logic                         restart;
    logic [macd_pkg::ALPHA_W-1:0] alpha_val;
    logic [31:0]                  rand_word;
    stim_row_t                    row;

    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = macd_pkg::CFG_SHORT_ALPHA;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    level     = 64'd100 << 16;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    for (n = 0; n < NUM_DIRECTED; n++) begin
      row = DIRECTED[n];
      sender_gap();
      send_price(row.price, row.restart, row.typed, row.want);
    end
    in_tvalid = 1'b0;
    wait_drained();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      for (n = 0; n < 3; n++) begin
        rand_word = $urandom_range(0, 131071);
        alpha_val = PHASE_RANDOM_ALPHA[phase] ? rand_word[macd_pkg::ALPHA_W-1:0]
                                              : PHASE_ALPHA[phase][n];
        write_alpha(2'(n), alpha_val);
      end
      idling = (phase % 3 != 2) && (phase != NUM_PHASES - 1);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == HOLD_PHASE && n == 40) hold_rx = 1'b1;
        if (phase == PAUSE_PHASE && n == 100) begin
          in_tvalid = 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        restart = (n == 0) || ($urandom_range(0, 49) == 0);
        case ($urandom_range(0, 19))
          0, 1, 2: level = longint'($urandom() & 32'h7FFFFFFF);
          3:       level = 0;
          4:       level = longint'(PRICE_TOP);
          default: begin
            span = 1 << $urandom_range(2, 26);
            if ($urandom_range(0, 1)) level = level + longint'($urandom_range(0, span));
            else level = level - longint'($urandom_range(0, span));
            level = sat(level, 0, longint'(PRICE_TOP));
          end
        endcase
        price = level[macd_pkg::PRICE_W-1:0];
        sender_gap();
        send_price(price, restart, 1'b0, ALL_ZERO);
      end
      in_tvalid = 1'b0;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("** macd_indicator_filter: PASSED **");
    end else begin
      $display("** macd_indicator_filter: FAILED **");
    end
    $finish;
  end

endmodule
